// ===== hdl/sfd_pkg.sv =====
// ---------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types of the fixed-length SLIP frame decoder.
// ---------------------------------------------------------------------------
package sfd_pkg;

    localparam int FRAME_BYTES = 12;

    localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CNT_W  = $clog2(FRAME_BYTES + 2);

    localparam logic [7:0] CODE_END     = 8'hC0;
    localparam logic [7:0] CODE_ESC     = 8'hDB;
    localparam logic [7:0] CODE_ESC_END = 8'hDC;
    localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic       we;
        t_addr      addr;
        logic [7:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic  re;
        t_addr addr;
    } t_ram_rd;

endpackage

// ===== hdl/sfd_if.sv =====
// ---------------------------------------------------------------------------
// sfd_rx_if, sfd_dec_if
// Valid/ready channels for received bytes and decoded frame bytes.
// ---------------------------------------------------------------------------
interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_dec_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/sfd_ram.sv =====
// ---------------------------------------------------------------------------
// sfd_ram
// Frame store: one write port and one read port with registered read data.
// The read data holds its value while no read is issued.
// ---------------------------------------------------------------------------
module sfd_ram (
    input  logic            i_clk,
    input  sfd_pkg::t_ram_wr i_wr,
    input  sfd_pkg::t_ram_rd i_rd,
    output logic [7:0]      o_rdata
);
    import sfd_pkg::*;

    logic [7:0] r_mem [FRAME_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/slip_fixed_frame_decoder_core.sv =====
// Input: one byte per cycle while collecting a frame.
// A closing END of a complete frame starts a readout; the first beat passes the state register,
// the frame store read data register and the output register. The frame then leaves at one
// beat per cycle while the sink is ready. Input is held off while the frame store read port
// streams the frame out, which takes longer when the output stalls.
// Reset is synchronous, active low, and clears the control state only; no clearing pass.
// ---------------------------------------------------------------------------
// slip_fixed_frame_decoder_core
// SLIP decoder that forwards only frames of exactly FRAME_BYTES decoded bytes.
// ---------------------------------------------------------------------------
module slip_fixed_frame_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfd_rx_if.sink      i_rx,
    sfd_dec_if.source   o_dec
);
    import sfd_pkg::*;

    localparam logic ST_RECV = 1'b0;
    localparam logic ST_READ = 1'b1;

    localparam t_addr LAST_ADDR = ADDR_W'(FRAME_BYTES - 1);
    localparam t_cnt  FULL_CNT  = CNT_W'(FRAME_BYTES);
    localparam t_cnt  OVER_CNT  = CNT_W'(FRAME_BYTES + 1);

    logic       r_state, n_state;
    logic       r_in_frame, n_in_frame;
    logic       r_esc, n_esc;
    t_cnt       r_cnt, n_cnt;
    t_addr      r_rd_addr, n_rd_addr;
    logic       r_rd_vld, n_rd_vld;
    logic       r_rd_last, n_rd_last;
    logic       r_out_vld, n_out_vld;
    logic [7:0] r_out_data;
    logic       r_out_last;

    t_ram_wr    w_wr;
    t_ram_rd    w_rd;
    logic [7:0] w_rdata;
    logic       w_accept;
    logic       w_out_load;
    logic       w_close_ok;
    logic       w_store;
    logic [7:0] w_store_data;

    sfd_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_rd    (w_rd),
        .o_rdata (w_rdata)
    );

    assign i_rx.ready      = (r_state == ST_RECV);
    assign w_accept        = i_rx.valid && i_rx.ready;
    assign w_out_load      = r_rd_vld && (!r_out_vld || o_dec.ready);
    assign w_close_ok      = w_accept && r_in_frame && !r_esc &&
                             (i_rx.rx_byte == CODE_END) && (r_cnt == FULL_CNT);

    always_comb begin
        n_state      = r_state;
        n_in_frame   = r_in_frame;
        n_esc        = r_esc;
        n_cnt        = r_cnt;
        n_rd_addr    = r_rd_addr;
        w_store      = 1'b0;
        w_store_data = i_rx.rx_byte;
        w_rd.re      = 1'b0;
        w_rd.addr    = r_rd_addr;

        if (w_accept) begin
            if (!r_in_frame) begin
                if (i_rx.rx_byte == CODE_END) begin
                    n_in_frame = 1'b1;
                    n_cnt      = '0;
                    n_esc      = 1'b0;
                end
            end else if (r_esc) begin
                n_esc = 1'b0;
                if (i_rx.rx_byte == CODE_ESC_END) begin
                    w_store      = 1'b1;
                    w_store_data = CODE_END;
                end else if (i_rx.rx_byte == CODE_ESC_ESC) begin
                    w_store      = 1'b1;
                    w_store_data = CODE_ESC;
                end
            end else if (i_rx.rx_byte == CODE_END) begin
                n_in_frame = 1'b0;
                n_cnt      = '0;
                if (r_cnt == FULL_CNT) begin
                    n_state   = ST_READ;
                    n_rd_addr = '0;
                end
            end else if (i_rx.rx_byte == CODE_ESC) begin
                n_esc = 1'b1;
            end else begin
                w_store = 1'b1;
            end
        end

        if (w_store) begin
            if (r_cnt < FULL_CNT) begin
                n_cnt = r_cnt + t_cnt'(1);
            end else begin
                n_cnt = OVER_CNT;
            end
        end

        if ((r_state == ST_READ) && (!r_rd_vld || w_out_load)) begin
            w_rd.re   = 1'b1;
            n_rd_addr = r_rd_addr + t_addr'(1);
            if (r_rd_addr == LAST_ADDR) begin
                n_state = ST_RECV;
            end
        end
    end

    always_comb begin
        w_wr.we   = w_store && (r_cnt < FULL_CNT);
        w_wr.addr = r_cnt[ADDR_W-1:0];
        w_wr.data = w_store_data;
    end

    always_comb begin
        n_rd_vld  = r_rd_vld;
        n_rd_last = r_rd_last;
        n_out_vld = r_out_vld;
        if (w_rd.re) begin
            n_rd_vld  = 1'b1;
            n_rd_last = (r_rd_addr == LAST_ADDR);
        end else if (w_out_load) begin
            n_rd_vld = 1'b0;
        end
        if (w_out_load) begin
            n_out_vld = 1'b1;
        end else if (o_dec.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RECV;
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_cnt      <= '0;
            r_rd_addr  <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_last  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_cnt      <= n_cnt;
            r_rd_addr  <= n_rd_addr;
            r_rd_vld   <= n_rd_vld;
            r_rd_last  <= n_rd_last;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_rdata;
            r_out_last <= r_rd_last;
        end
    end

    assign o_dec.valid     = r_out_vld;
    assign o_dec.data_byte = r_out_data;
    assign o_dec.last_byte = r_out_last;

`ifndef ASSERT_OFF
    a_no_write_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr.we && w_rd.re))
        else $error("Frame store written while a readout read is issued.");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= OVER_CNT)
        else $error("Byte count beyond saturation value.");

    a_rdata_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld && !w_out_load) |=> (r_rd_vld && $stable(w_rdata)))
        else $error("Pending read data was overwritten before it was taken.");

    a_close_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close_ok |=> ((r_state == ST_READ) && (r_rd_addr == '0) && !r_in_frame))
        else $error("Complete frame did not start a readout.");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the fixed-length SLIP frame decoder against a cycle-free predictor.
// Raw link bytes are queued up front, sent in bursts with random gaps, and
// every decoded beat is compared in order with the predicted frame contents
// while the receiver stalls on a shifting pattern.
// ---------------------------------------------------------------------------
module testbench;
    import sfd_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_dec_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sfd_rx_if  rx_ch ();
    sfd_dec_if dec_ch ();

    slip_fixed_frame_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_dec   (dec_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [7:0] link_bytes_q[$];
    t_dec_beat  due_beats_q[$];

    int errors = 0;
    int bytes_queued = 0;
    int bytes_taken = 0;
    int frames_sent = 0;
    int frames_decoded = 0;
    int beats_checked = 0;

    // Predictor state.
    logic       pr_in_frame = 1'b0;
    logic       pr_escaped = 1'b0;
    t_cnt       pr_count = '0;
    logic [7:0] pr_store [FRAME_BYTES];

    task automatic store_decoded(input logic [7:0] b);
        if (pr_count < t_cnt'(FRAME_BYTES)) begin
            pr_store[pr_count] = b;
            pr_count = pr_count + t_cnt'(1);
        end else begin
            pr_count = t_cnt'(FRAME_BYTES + 1);
        end
    endtask

    task automatic slip_decode(input logic [7:0] b);
        t_dec_beat beat;
        if (!pr_in_frame) begin
            if (b == CODE_END) begin
                pr_in_frame = 1'b1;
                pr_count = '0;
                pr_escaped = 1'b0;
            end
        end else if (pr_escaped) begin
            pr_escaped = 1'b0;
            if (b == CODE_ESC_END) begin
                store_decoded(CODE_END);
            end else if (b == CODE_ESC_ESC) begin
                store_decoded(CODE_ESC);
            end
        end else if (b == CODE_END) begin
            if (pr_count == t_cnt'(FRAME_BYTES)) begin
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    beat.data_byte = pr_store[i];
                    beat.last_byte = (i == FRAME_BYTES - 1);
                    due_beats_q.push_back(beat);
                end
                frames_decoded++;
            end
            pr_in_frame = 1'b0;
            pr_count = '0;
        end else if (b == CODE_ESC) begin
            pr_escaped = 1'b1;
        end else begin
            store_decoded(b);
        end
    endtask

    // Stimulus helpers.
    task automatic push_raw(input logic [7:0] b);
        link_bytes_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_encoded(input logic [7:0] b);
        if (b == CODE_END) begin
            push_raw(CODE_ESC);
            push_raw(CODE_ESC_END);
        end else if (b == CODE_ESC) begin
            push_raw(CODE_ESC);
            push_raw(CODE_ESC_ESC);
        end else begin
            push_raw(b);
        end
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0: pick_payload = CODE_END;
            1: pick_payload = CODE_ESC;
            2: pick_payload = ($urandom_range(0, 1) != 0) ? CODE_ESC_END : CODE_ESC_ESC;
            3: pick_payload = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
            default: pick_payload = 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_bad_escape();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: b = CODE_END;
            1: b = CODE_ESC;
            default: b = 8'($urandom_range(0, 255));
        endcase
        if (b == CODE_ESC_END || b == CODE_ESC_ESC) begin
            b = 8'h55;
        end
        pick_bad_escape = b;
    endfunction

    task automatic push_frame(input int n, input bit bad_escapes);
        push_raw(CODE_END);
        for (int i = 0; i < n; i++) begin
            if (bad_escapes && $urandom_range(0, 3) == 0) begin
                push_raw(CODE_ESC);
                push_raw(pick_bad_escape());
            end
            push_encoded(pick_payload());
        end
        push_raw(CODE_END);
        frames_sent++;
    endtask

    task automatic push_garbled_frame(input int n);
        logic [7:0] b;
        push_raw(CODE_END);
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == CODE_END || (i == n - 1 && b == CODE_ESC)) begin
                b = 8'hA5;
            end
            push_raw(b);
        end
        push_raw(CODE_END);
        frames_sent++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else if (!rx_ch.valid || rx_ch.ready) begin
            if (rx_ch.valid) begin
                slip_decode(rx_ch.rx_byte);
                bytes_taken++;
            end
            if (gap_left > 0) begin
                gap_left--;
                rx_ch.valid <= 1'b0;
            end else if (link_bytes_q.size() > 0) begin
                rx_ch.valid <= 1'b1;
                rx_ch.rx_byte <= link_bytes_q.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                             : $urandom_range(1, 20);
                    gap_left = $urandom_range(1, 7);
                end
            end else begin
                rx_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern steps through four modes, from always ready to mostly stalled.
    int stall_cycle = 0;

    always @(posedge i_clk) begin
        t_dec_beat due;
        if (!i_rst_n) begin
            dec_ch.ready <= 1'b0;
        end else begin
            if (dec_ch.valid && dec_ch.ready) begin
                if (due_beats_q.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual data %02h last %0b",
                             $time, dec_ch.data_byte, dec_ch.last_byte);
                    errors++;
                end else begin
                    due = due_beats_q.pop_front();
                    if (dec_ch.data_byte !== due.data_byte) begin
                        $display("%0t: data_byte mismatch: expected %02h, actual %02h",
                                 $time, due.data_byte, dec_ch.data_byte);
                        errors++;
                    end
                    if (dec_ch.last_byte !== due.last_byte) begin
                        $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                                 $time, due.last_byte, dec_ch.last_byte);
                        errors++;
                    end
                    beats_checked++;
                end
            end
            case ((stall_cycle / 97) % 4)
                0: dec_ch.ready <= 1'b1;
                1: dec_ch.ready <= ($urandom_range(0, 3) != 0);
                2: dec_ch.ready <= ((stall_cycle % 7) < 4);
                default: dec_ch.ready <= ($urandom_range(0, 9) < 2);
            endcase
            stall_cycle++;
        end
    end

    initial begin
        int sel;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'h00;
        dec_ch.ready = 1'b0;

        // Bytes outside a frame, including an ESC, are ignored.
        push_raw(8'h00);
        push_raw(CODE_ESC);
        push_raw(CODE_ESC_END);
        // Full frame with both escapes, an escaped END and ESC that are invalid.
        push_raw(CODE_END);
        push_raw(8'h00);
        push_raw(8'hFF);
        push_raw(CODE_ESC);
        push_raw(CODE_ESC_END);
        push_raw(CODE_ESC);
        push_raw(CODE_ESC_ESC);
        push_raw(CODE_ESC);
        push_raw(CODE_END);
        push_raw(CODE_ESC);
        push_raw(CODE_ESC);
        for (int i = 0; i < FRAME_BYTES - 4; i++) begin
            push_raw(8'(8'h11 * (i + 1)));
        end
        push_raw(CODE_END);
        frames_sent++;
        // Empty frame.
        push_raw(CODE_END);
        push_raw(CODE_END);
        push_raw(CODE_ESC);

        while (bytes_queued < 520) begin
            sel = $urandom_range(0, 99);
            if (sel < 58) begin
                push_frame(FRAME_BYTES, 1'b0);
            end else if (sel < 66) begin
                push_frame($urandom_range(0, FRAME_BYTES - 1), 1'b0);
            end else if (sel < 74) begin
                push_frame($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 4), 1'b0);
            end else if (sel < 86) begin
                push_frame(FRAME_BYTES, 1'b1);
            end else if (sel < 93) begin
                push_garbled_frame($urandom_range(1, FRAME_BYTES + 4));
            end else begin
                for (int i = $urandom_range(1, 4); i > 0; i--) begin
                    sel = $urandom_range(0, 255);
                    push_raw((8'(sel) == CODE_END) ? CODE_ESC : 8'(sel));
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != bytes_queued) @(posedge i_clk);
        while (due_beats_q.size() != 0) @(posedge i_clk);
        repeat (4 * FRAME_BYTES) @(posedge i_clk);

        $display("Sent %0d link bytes in %0d frames plus noise; checked %0d beats of %0d frames.",
                 bytes_taken, frames_sent, beats_checked, frames_decoded);
        if (errors == 0 && due_beats_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d beats still due", $time, due_beats_q.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sfd_pkg.sv
hdl/sfd_if.sv
hdl/sfd_ram.sv
hdl/slip_fixed_frame_decoder_core.sv
test/testbench.sv
